FILE: hdl/osc_pkg.sv
package osc_pkg;

  localparam int unsigned CHANNELS_DEF = 2;
  localparam int unsigned ADDR_W       = 5;
  localparam int unsigned MUL_W        = 34;
  localparam int unsigned PROD_W       = 2 * MUL_W;
  localparam int unsigned DIV_NUM_W    = 64;
  localparam int unsigned DIV_DEN_W    = 66;
  localparam int unsigned DIV_QW       = 25;

  // register indexes, taken from paddr[4:2]
  localparam logic [2:0] REG_HP_COEFF   = 3'd0;
  localparam logic [2:0] REG_MID_B0     = 3'd1;
  localparam logic [2:0] REG_MID_A1     = 3'd2;
  localparam logic [2:0] REG_MID_A2     = 3'd3;
  localparam logic [2:0] REG_MID_GAIN   = 3'd4;
  localparam logic [2:0] REG_DRIVE      = 3'd5;
  localparam logic [2:0] REG_TONE_COEFF = 3'd6;
  localparam logic [2:0] REG_LEVEL      = 3'd7;

  localparam logic signed [23:0] HP_COEFF_RST = 24'sd4173332;
  localparam logic [22:0]        MID_GAIN_RST = 23'd4194304;
  localparam logic [16:0]        DRIVE_RST    = 17'd32768;
  localparam logic [22:0]        TONE_RST     = 23'd2097152;
  localparam logic [16:0]        LEVEL_RST    = 17'd65536;

  localparam logic [16:0] UNITY_Q16  = 17'd65536;
  localparam logic [24:0] ONE_Q22    = 25'd4194304;
  localparam logic [23:0] ONE_Q23    = 24'd8388608;
  localparam logic [63:0] CLIP_NUM   = 64'd5872026 << 16;
  localparam logic [33:0] LIM_SCALE  = 34'd58982;
  localparam logic [24:0] LIM_MAX    = 25'd25165824;
  localparam logic [28:0] LIM_K      = 29'd226492416;
  // ceil(2^30 / 10): exact division by ten for numerators below 2^27
  localparam logic [33:0] THN_RECIP  = 34'd107374183;

  typedef struct packed {
    logic signed [23:0] hp_coeff;
    logic signed [23:0] mid_b0;
    logic signed [23:0] mid_a1;
    logic signed [23:0] mid_a2;
    logic [22:0]        mid_gain;
    logic [16:0]        drive;
    logic [22:0]        tone;
    logic [16:0]        level;
  } cfg_t;

  function automatic logic signed [PROD_W-1:0] sx68(input logic signed [31:0] v);
    return {{(PROD_W-32){v[31]}}, v};
  endfunction

  // add half, then floor shift
  function automatic logic signed [PROD_W-1:0] rnd_shr(input logic signed [PROD_W-1:0] v,
                                                      input int unsigned n);
    logic signed [PROD_W-1:0] half;
    half = 68'sd1 <<< (n - 1);
    return (v + half) >>> n;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [PROD_W-1:0] v);
    if (v > 68'sd2147483647) return 32'sh7FFFFFFF;
    else if (v < -68'sd2147483648) return 32'sh80000000;
    else return v[31:0];
  endfunction

endpackage

FILE: hdl/overdrive_sample_chain.sv
// Channel  Dir  Handshake              Word
// s_axis   in   tvalid/tready          tdata[23:0] sample_in, tuser[0] channel
// m_axis   out  tvalid/tready          tdata[23:0] sample_out, tuser[0] out_channel
// apb      in   psel/penable, pready=1 8 registers at byte address 4*i
//
// Each word runs from acceptance to the next ready through fourteen passes of the
// shared 34x34 multiplier (the three band-pass products overlapped), two runs of
// the shared restoring divider (clip threshold, limiter quotient), and, when the
// sample lands beyond a clip threshold, three more products plus the knee quotient.
// Reset sets the register defaults and clears the per-channel filter memories and the control.
// The input is taken only while the sequencer idles; a finished word waits in
// the output register, so the next input word can start while it is stalled.
module overdrive_sample_chain
  import osc_pkg::*;
#(
  parameter int unsigned CHANNELS = CHANNELS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [23:0]       s_axis_tdata,   // [23:0] sample_in
  input  logic              s_axis_tuser,   // [0] channel
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [23:0]       m_axis_tdata,   // [23:0] sample_out
  output logic              m_axis_tuser,   // [0] out_channel
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  localparam int unsigned CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  typedef enum logic [5:0] {
    ST_IDLE,
    ST_HPI_M, ST_HPI_C,
    ST_DRV_M, ST_DRV_C,
    ST_B0_M, ST_A1_M, ST_A2_M, ST_BP_C,
    ST_MG_M, ST_MG_C,
    ST_BL_M, ST_BL_C,
    ST_THR_D, ST_THR_W, ST_THN_M, ST_THN_C,
    ST_CLP,
    ST_RR_M, ST_EE_M, ST_EE_C, ST_F_D, ST_F_W, ST_EF_M, ST_EF_C,
    ST_TN_M, ST_TN_C,
    ST_LV_M, ST_LV_C,
    ST_HPO_M, ST_HPO_C,
    ST_LS_M, ST_LS_C,
    ST_X2_M, ST_X2_C, ST_NUM_M, ST_NUM_C,
    ST_Y_D, ST_Y_W,
    ST_OUT
  } state_e;

  cfg_t cfg;

  state_e                   state_q;
  logic [CH_W-1:0]          ch_q;
  logic                     chbit_q;
  logic signed [31:0]       s_q;
  logic signed [31:0]       tmp_q;
  logic signed [PROD_W-1:0] acc_q;
  logic [22:0]              thr_q;
  logic [22:0]              thrn_q;
  logic                     pos_q;
  logic [31:0]              e_q;
  logic [46:0]              r2_q;
  logic [17:0]              f_q;
  logic [DIV_DEN_W-1:0]     den_q;
  logic [DIV_NUM_W-1:0]     num_q;
  logic                     neg_q;
  logic [24:0]              ax_q;
  logic [26:0]              x2_q;
  logic [23:0]              res_q;
  logic                     ov_q;
  logic [23:0]              od_q;
  logic                     och_q;

  logic signed [31:0] hpi_mem_q [CHANNELS];
  logic signed [31:0] z1_mem_q  [CHANNELS];
  logic signed [31:0] z2_mem_q  [CHANNELS];
  logic signed [31:0] tone_mem_q[CHANNELS];
  logic signed [31:0] hpo_mem_q [CHANNELS];

  logic signed [MUL_W-1:0]  op_a, op_b;
  logic signed [PROD_W-1:0] prod;
  logic                     div_start;
  logic                     div_done;
  logic [DIV_QW-1:0]        quo;
  logic [DIV_NUM_W-1:0]     div_num;
  logic [DIV_DEN_W-1:0]     div_den;

  logic [16:0]        d_sat, lv_sat;
  logic signed [24:0] hp_m1;
  logic [23:0]        d99;
  logic [19:0]        tden;
  logic [22:0]        tv;
  logic [23:0]        rr;
  logic signed [31:0] thr_s, thrn_s;
  logic signed [32:0] e_pos, e_neg;
  logic signed [PROD_W-1:0] lim_in, lim_abs;
  logic [24:0]        yc;

  osc_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  osc_mul u_mul (
    .clk_i  (clk_i),
    .a_i    (op_a),
    .b_i    (op_b),
    .prod_o (prod)
  );

  osc_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quo_o   (quo)
  );

  // saturate drive and level to unity
  assign d_sat  = (cfg.drive > UNITY_Q16) ? UNITY_Q16 : cfg.drive;
  assign lv_sat = (cfg.level > UNITY_Q16) ? UNITY_Q16 : cfg.level;
  assign hp_m1  = {cfg.hp_coeff[23], cfg.hp_coeff} - $signed(ONE_Q22);
  assign d99    = ({7'b0, d_sat} << 6) + ({7'b0, d_sat} << 5) + ({7'b0, d_sat} << 1)
                + {7'b0, d_sat};
  assign tden   = 20'd65536 + ({3'b0, d_sat} << 3) + {3'b0, d_sat};
  assign tv     = pos_q ? thr_q : thrn_q;
  assign rr     = ONE_Q23 - {1'b0, tv};
  assign thr_s  = $signed({9'b0, thr_q});
  assign thrn_s = -$signed({9'b0, thrn_q});
  assign e_pos  = {s_q[31], s_q} - {thr_s[31], thr_s};
  assign e_neg  = {thrn_s[31], thrn_s} - {s_q[31], s_q};

  // limiter input, its magnitude and the clamped quotient
  assign lim_in  = rnd_shr(prod, 16);
  assign lim_abs = lim_in[PROD_W-1] ? -lim_in : lim_in;
  assign yc      = (quo > {1'b0, ONE_Q23}) ? {1'b0, ONE_Q23} : quo;

  // operand select for the shared multiplier
  always_comb begin
    op_a = '0;
    op_b = '0;
    unique case (state_q)
      ST_HPI_M: begin
        op_a = MUL_W'(hp_m1);
        op_b = MUL_W'(hpi_mem_q[ch_q]);
      end
      ST_DRV_M: begin
        op_a = {10'b0, d99};
        op_b = MUL_W'(s_q);
      end
      ST_B0_M: begin
        op_a = MUL_W'(cfg.mid_b0);
        op_b = MUL_W'(s_q) - MUL_W'(z2_mem_q[ch_q]);
      end
      ST_A1_M: begin
        op_a = MUL_W'(cfg.mid_a1);
        op_b = MUL_W'(z1_mem_q[ch_q]);
      end
      ST_A2_M: begin
        op_a = MUL_W'(cfg.mid_a2);
        op_b = MUL_W'(z2_mem_q[ch_q]);
      end
      ST_MG_M: begin
        op_a = MUL_W'(tmp_q);
        op_b = {11'b0, cfg.mid_gain};
      end
      ST_BL_M: begin
        op_a = MUL_W'(tmp_q) - MUL_W'(s_q);
        op_b = {17'b0, d_sat};
      end
      // negative threshold: (7*thr + 5) / 10 by reciprocal
      ST_THN_M: begin
        op_a = MUL_W'({thr_q, 3'b0}) - MUL_W'(thr_q) + MUL_W'(5);
        op_b = THN_RECIP;
      end
      ST_RR_M: begin
        op_a = {10'b0, rr};
        op_b = {10'b0, rr};
      end
      ST_EE_M: begin
        op_a = {2'b0, e_q};
        op_b = {2'b0, e_q};
      end
      ST_EF_M: begin
        op_a = {2'b0, e_q};
        op_b = {16'b0, f_q};
      end
      ST_TN_M: begin
        op_a = MUL_W'(s_q) - MUL_W'(tone_mem_q[ch_q]);
        op_b = {11'b0, cfg.tone};
      end
      ST_LV_M: begin
        op_a = MUL_W'(s_q);
        op_b = {17'b0, lv_sat};
      end
      ST_HPO_M: begin
        op_a = MUL_W'(hp_m1);
        op_b = MUL_W'(hpo_mem_q[ch_q]);
      end
      ST_LS_M: begin
        op_a = MUL_W'(s_q);
        op_b = LIM_SCALE;
      end
      ST_X2_M: begin
        op_a = {9'b0, ax_q};
        op_b = {9'b0, ax_q};
      end
      ST_NUM_M: begin
        op_a = {9'b0, ax_q};
        op_b = {5'b0, LIM_K + 29'(x2_q)};
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  // operand select for the shared divider
  always_comb begin
    div_start = 1'b1;
    div_num   = '0;
    div_den   = '0;
    unique case (state_q)
      ST_THR_D: begin
        div_num = CLIP_NUM + DIV_NUM_W'(tden >> 1);
        div_den = DIV_DEN_W'(tden);
      end
      ST_F_D: begin
        div_num = {r2_q, 17'b0};
        div_den = den_q;
      end
      ST_Y_D: begin
        div_num = num_q;
        div_den = den_q;
      end
      default: div_start = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ov_q    <= 1'b0;
      for (int i = 0; i < CHANNELS; i++) begin
        hpi_mem_q[i]  <= '0;
        z1_mem_q[i]   <= '0;
        z2_mem_q[i]   <= '0;
        tone_mem_q[i] <= '0;
        hpo_mem_q[i]  <= '0;
      end
    end else begin
      // drop the output word once taken, unless a new one is loaded below
      if (ov_q && m_axis_tready && state_q != ST_OUT) ov_q <= 1'b0;
      unique case (state_q)
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            s_q     <= {{8{s_axis_tdata[23]}}, s_axis_tdata};
            chbit_q <= s_axis_tuser;
            ch_q    <= (CHANNELS > 1) ? CH_W'(s_axis_tuser) : '0;
            state_q <= ST_HPI_M;
          end
        end
        ST_HPI_M: state_q <= ST_HPI_C;
        ST_HPI_C: begin
          s_q               <= sat32(sx68(s_q) + rnd_shr(prod, 22));
          hpi_mem_q[ch_q]   <= sat32(sx68(s_q) + rnd_shr(prod, 22));
          state_q           <= ST_DRV_M;
        end
        ST_DRV_M: state_q <= ST_DRV_C;
        ST_DRV_C: begin
          s_q     <= sat32(sx68(s_q) + rnd_shr(prod, 16));
          state_q <= ST_B0_M;
        end
        // band-pass: accumulate three products
        ST_B0_M: state_q <= ST_A1_M;
        ST_A1_M: begin
          acc_q   <= prod;
          state_q <= ST_A2_M;
        end
        ST_A2_M: begin
          acc_q   <= acc_q - prod;
          state_q <= ST_BP_C;
        end
        ST_BP_C: begin
          tmp_q          <= sat32(rnd_shr(acc_q - prod, 22));
          z1_mem_q[ch_q] <= sat32(rnd_shr(acc_q - prod, 22));
          z2_mem_q[ch_q] <= z1_mem_q[ch_q];
          state_q        <= ST_MG_M;
        end
        ST_MG_M: state_q <= ST_MG_C;
        ST_MG_C: begin
          tmp_q   <= sat32(rnd_shr(prod, 22));
          state_q <= ST_BL_M;
        end
        ST_BL_M: state_q <= ST_BL_C;
        ST_BL_C: begin
          s_q     <= sat32(sx68(s_q) + rnd_shr(prod, 17));
          state_q <= ST_THR_D;
        end
        ST_THR_D: state_q <= ST_THR_W;
        ST_THR_W: begin
          if (div_done) begin
            thr_q   <= quo[22:0];
            state_q <= ST_THN_M;
          end
        end
        ST_THN_M: state_q <= ST_THN_C;
        ST_THN_C: begin
          thrn_q  <= prod[52:30];
          state_q <= ST_CLP;
        end
        ST_CLP: begin
          if (s_q > thr_s) begin
            pos_q   <= 1'b1;
            e_q     <= e_pos[31:0];
            state_q <= ST_RR_M;
          end else if (s_q < thrn_s) begin
            pos_q   <= 1'b0;
            e_q     <= e_neg[31:0];
            state_q <= ST_RR_M;
          end else begin
            state_q <= ST_TN_M;
          end
        end
        ST_RR_M: state_q <= ST_EE_M;
        ST_EE_M: begin
          r2_q    <= prod[46:0];
          state_q <= ST_EE_C;
        end
        ST_EE_C: begin
          den_q   <= DIV_DEN_W'(r2_q) + prod[DIV_DEN_W-1:0];
          state_q <= ST_F_D;
        end
        ST_F_D: state_q <= ST_F_W;
        ST_F_W: begin
          if (div_done) begin
            f_q     <= quo[17:0];
            state_q <= ST_EF_M;
          end
        end
        ST_EF_M: state_q <= ST_EF_C;
        ST_EF_C: begin
          s_q     <= pos_q ? thr_s + $signed(prod[48:17]) : thrn_s - $signed(prod[48:17]);
          state_q <= ST_TN_M;
        end
        ST_TN_M: state_q <= ST_TN_C;
        ST_TN_C: begin
          s_q              <= sat32(sx68(tone_mem_q[ch_q]) + rnd_shr(prod, 22));
          tone_mem_q[ch_q] <= sat32(sx68(tone_mem_q[ch_q]) + rnd_shr(prod, 22));
          state_q          <= ST_LV_M;
        end
        ST_LV_M: state_q <= ST_LV_C;
        ST_LV_C: begin
          // level is at most unity, so the scaled sample stays in 32 bits
          s_q     <= 32'(rnd_shr(prod, 16));
          state_q <= ST_HPO_M;
        end
        ST_HPO_M: state_q <= ST_HPO_C;
        ST_HPO_C: begin
          s_q             <= sat32(sx68(s_q) + rnd_shr(prod, 22));
          hpo_mem_q[ch_q] <= sat32(sx68(s_q) + rnd_shr(prod, 22));
          state_q         <= ST_LS_M;
        end
        ST_LS_M: state_q <= ST_LS_C;
        ST_LS_C: begin
          neg_q   <= lim_in[PROD_W-1];
          ax_q    <= (lim_abs > PROD_W'(LIM_MAX)) ? LIM_MAX : lim_abs[24:0];
          state_q <= ST_X2_M;
        end
        ST_X2_M: state_q <= ST_X2_C;
        ST_X2_C: begin
          x2_q    <= 27'((prod + PROD_W'(ONE_Q22)) >>> 23);
          state_q <= ST_NUM_M;
        end
        ST_NUM_M: state_q <= ST_NUM_C;
        ST_NUM_C: begin
          num_q   <= prod[DIV_NUM_W-1:0];
          den_q   <= DIV_DEN_W'(LIM_K) + DIV_DEN_W'({x2_q, 3'b0}) + DIV_DEN_W'(x2_q);
          state_q <= ST_Y_D;
        end
        ST_Y_D: state_q <= ST_Y_W;
        ST_Y_W: begin
          if (div_done) begin
            if (neg_q) res_q <= 24'(25'd0 - yc);
            else       res_q <= (yc >= {1'b0, ONE_Q23}) ? 24'h7FFFFF : yc[23:0];
            state_q <= ST_OUT;
          end
        end
        ST_OUT: begin
          // hold until the output register is free
          if (!ov_q || m_axis_tready) begin
            ov_q    <= 1'b1;
            od_q    <= res_q;
            och_q   <= chbit_q;
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = od_q;
  assign m_axis_tuser  = och_q;

  a_accept_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> state_q != ST_IDLE)
    else $error("word accepted but sequencer stayed idle");
  a_div_wait : assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == ST_THR_W || state_q == ST_F_W || state_q == ST_Y_W))
    else $error("divider result outside a wait state");
  a_out_load : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_OUT && (!ov_q || m_axis_tready) |=> ov_q && state_q == ST_IDLE)
    else $error("result word not loaded");

endmodule

FILE: hdl/osc_mul.sv
module osc_mul
  import osc_pkg::*;
(
  input  logic                     clk_i,
  input  logic signed [MUL_W-1:0]  a_i,
  input  logic signed [MUL_W-1:0]  b_i,
  output logic signed [PROD_W-1:0] prod_o
);

  logic signed [PROD_W-1:0] prod_q;

  // register every product; the sequencer picks it up next cycle
  always_ff @(posedge clk_i) begin
    prod_q <= a_i * b_i;
  end

  assign prod_o = prod_q;

endmodule

FILE: hdl/osc_div.sv
module osc_div
  import osc_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [DIV_NUM_W-1:0] num_i,
  input  logic [DIV_DEN_W-1:0] den_i,
  output logic                 done_o,
  output logic [DIV_QW-1:0]    quo_o
);

  localparam int unsigned SH_W  = DIV_DEN_W + DIV_QW - 1;
  localparam int unsigned CNT_W = $clog2(DIV_QW + 1);

  logic [DIV_NUM_W-1:0] rem_q;
  logic [SH_W-1:0]      dsh_q;
  logic [DIV_QW-1:0]    quo_q;
  logic [CNT_W-1:0]     cnt_q;
  logic                 run_q;
  logic                 done_q;
  logic                 fits;

  // quotient is known to stay below 2^DIV_QW, so the restoring steps start at bit DIV_QW-1
  assign fits = {{(SH_W-DIV_NUM_W){1'b0}}, rem_q} >= dsh_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= CNT_W'(DIV_QW);
      end else if (run_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CNT_W'(1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= num_i;
      dsh_q <= {den_i, {(DIV_QW-1){1'b0}}};
      quo_q <= '0;
    end else if (run_q) begin
      if (fits) rem_q <= rem_q - dsh_q[DIV_NUM_W-1:0];
      quo_q <= {quo_q[DIV_QW-2:0], fits};
      dsh_q <= dsh_q >> 1;
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

  a_start_runs : assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |=> run_q) else $error("divider did not start");
  a_done_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !run_q) else $error("divider done while running");
  a_last_done : assert property (@(posedge clk_i) disable iff (!rst_ni)
    run_q && !start_i && cnt_q == CNT_W'(1) |=> done_q) else $error("divider missed done");

endmodule

FILE: hdl/osc_regs.sv
module osc_regs
  import osc_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output cfg_t              cfg_o
);

  cfg_t       cfg_q;
  logic [2:0] idx;

  assign idx    = paddr[ADDR_W-1:2];
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.hp_coeff <= HP_COEFF_RST;
      cfg_q.mid_b0   <= '0;
      cfg_q.mid_a1   <= '0;
      cfg_q.mid_a2   <= '0;
      cfg_q.mid_gain <= MID_GAIN_RST;
      cfg_q.drive    <= DRIVE_RST;
      cfg_q.tone     <= TONE_RST;
      cfg_q.level    <= LEVEL_RST;
    end else if (psel && penable && pwrite) begin
      unique case (idx)
        REG_HP_COEFF:   cfg_q.hp_coeff <= pwdata[23:0];
        REG_MID_B0:     cfg_q.mid_b0   <= pwdata[23:0];
        REG_MID_A1:     cfg_q.mid_a1   <= pwdata[23:0];
        REG_MID_A2:     cfg_q.mid_a2   <= pwdata[23:0];
        REG_MID_GAIN:   cfg_q.mid_gain <= pwdata[22:0];
        REG_DRIVE:      cfg_q.drive    <= pwdata[16:0];
        REG_TONE_COEFF: cfg_q.tone     <= pwdata[22:0];
        REG_LEVEL:      cfg_q.level    <= pwdata[16:0];
        default:        cfg_q.level    <= cfg_q.level;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_HP_COEFF:   prdata = {8'b0, cfg_q.hp_coeff};
      REG_MID_B0:     prdata = {8'b0, cfg_q.mid_b0};
      REG_MID_A1:     prdata = {8'b0, cfg_q.mid_a1};
      REG_MID_A2:     prdata = {8'b0, cfg_q.mid_a2};
      REG_MID_GAIN:   prdata = {9'b0, cfg_q.mid_gain};
      REG_DRIVE:      prdata = {15'b0, cfg_q.drive};
      REG_TONE_COEFF: prdata = {9'b0, cfg_q.tone};
      REG_LEVEL:      prdata = {15'b0, cfg_q.level};
      default:        prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule
